FILE: sv/sphere_obstacle_avoidance_top_assert.svh
// ----------------------------------------------------------------------------
// Sphere obstacle avoidance assertion macros
// Assertion wrappers shared by the modules of the block. They expand to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SPHERE_OBSTACLE_AVOIDANCE_TOP_ASSERT_SVH
`define SPHERE_OBSTACLE_AVOIDANCE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SOA_ASSERT_IMPLY(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("sphere avoidance check failed");
`define SOA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("sphere avoidance check failed");
`else
`define SOA_ASSERT_IMPLY(lbl, pre, post)
`define SOA_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

FILE: sv/soa_pkg.sv
// ----------------------------------------------------------------------------
// Sphere obstacle avoidance package
// Shared types, register codes and helper functions.
// ----------------------------------------------------------------------------
package soa_pkg;

  localparam logic [30:0] DIST_NONE = 31'h7FFF_FFFF;

  localparam logic [2:0] REG_CHAR_X     = 3'd0;
  localparam logic [2:0] REG_CHAR_Y     = 3'd1;
  localparam logic [2:0] REG_CHAR_Z     = 3'd2;
  localparam logic [2:0] REG_GOAL_X     = 3'd3;
  localparam logic [2:0] REG_GOAL_Y     = 3'd4;
  localparam logic [2:0] REG_GOAL_Z     = 3'd5;
  localparam logic [2:0] REG_GOAL_VALID = 3'd6;
  localparam logic [2:0] REG_MARGIN     = 3'd7;

  localparam logic MODE_SQRT = 1'b0;
  localparam logic MODE_DIV  = 1'b1;

  typedef struct packed {
    logic signed [31:0] char_x;
    logic signed [31:0] char_y;
    logic signed [31:0] char_z;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [31:0] goal_z;
    logic               goal_valid;
    logic [30:0]        avoid_margin;
  } soa_cfg_t;

  typedef struct packed {
    logic start;
    logic mode;
  } soa_iter_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } soa_iter_sts_t;

  typedef struct packed {
    logic               found;
    logic [30:0]        distance;
    logic signed [31:0] avoid_x;
    logic signed [31:0] avoid_y;
    logic signed [31:0] avoid_z;
  } soa_res_t;

  function automatic logic signed [65:0] sx32(input logic [31:0] v);
    return {{34{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

FILE: sv/soa_iter.sv
// ----------------------------------------------------------------------------
// Sphere obstacle avoidance iterative unit
// Shared restoring square root and divider, one result bit per cycle.
// ----------------------------------------------------------------------------
module soa_iter import soa_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  soa_iter_req_t req,
  input  logic [63:0]   opa,
  input  logic [31:0]   opb,
  output soa_iter_sts_t sts,
  output logic [31:0]   result
);

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = FRAC_BITS + 1;

  logic        busy_r;
  logic        done_r;
  logic        mode_r;
  logic        first_r;
  logic [5:0]  cnt_r;
  logic [35:0] rem_r;
  logic [31:0] root_r;
  logic [63:0] num_r;
  logic [31:0] den_r;

  logic [35:0] cand;
  logic [35:0] trial;
  logic [36:0] diff;
  logic        ge;

  always_comb begin
    if (mode_r == MODE_SQRT) begin
      cand  = {rem_r[33:0], num_r[63:62]};
      trial = {2'b00, root_r, 2'b01};
    end else begin
      cand  = first_r ? rem_r : {rem_r[34:0], 1'b0};
      trial = {4'b0000, den_r};
    end
    diff = {1'b0, cand} - {1'b0, trial};
    ge   = ~diff[36];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      mode_r  <= MODE_SQRT;
      first_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r  <= 1'b1;
        mode_r  <= req.mode;
        first_r <= 1'b1;
        cnt_r   <= (req.mode == MODE_SQRT) ? 6'(SQRT_STEPS - 1) : 6'(DIV_STEPS - 1);
      end else if (busy_r) begin
        first_r <= 1'b0;
        cnt_r   <= cnt_r - 6'd1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= (req.mode == MODE_SQRT) ? 36'd0 : {4'b0000, opa[31:0]};
      root_r <= '0;
      num_r  <= opa;
      den_r  <= opb;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[35:0] : cand;
      root_r <= {root_r[30:0], ge};
      num_r  <= {num_r[61:0], 2'b00};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign result   = root_r;

endmodule

FILE: sv/soa_core.sv
// ----------------------------------------------------------------------------
// Sphere obstacle avoidance core
// Sequencer and shared multiplier for one obstacle request, and the running best hit up to the request marked last.
// ----------------------------------------------------------------------------
`include "sphere_obstacle_avoidance_top_assert.svh"
module soa_core import soa_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  soa_cfg_t           cfg,
  input  logic               item_go,
  input  logic signed [31:0] ob_x,
  input  logic signed [31:0] ob_y,
  input  logic signed [31:0] ob_z,
  input  logic [30:0]        ob_radius,
  input  logic               ob_last,
  output logic               idle,
  input  logic               res_ready,
  output logic               res_load,
  output soa_res_t           res
);

  localparam int UW = FRAC_BITS + 2;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SUMSQ   = 4'd1;
  localparam logic [3:0] ST_SQRT    = 4'd2;
  localparam logic [3:0] ST_SQWAIT  = 4'd3;
  localparam logic [3:0] ST_DIVGO   = 4'd4;
  localparam logic [3:0] ST_DIVWAIT = 4'd5;
  localparam logic [3:0] ST_DOT     = 4'd6;
  localparam logic [3:0] ST_RANGE   = 4'd7;
  localparam logic [3:0] ST_HIT     = 4'd8;
  localparam logic [3:0] ST_HITCHK  = 4'd9;
  localparam logic [3:0] ST_OFF     = 4'd10;
  localparam logic [3:0] ST_PT      = 4'd11;
  localparam logic [3:0] ST_DONE    = 4'd12;

  logic [3:0]  state_r, state_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        pass_r, pass_nxt;
  logic [1:0]  prv_r;
  logic [30:0] best_dist_r, best_dist_nxt;

  logic               last_r, last_nxt;
  logic [31:0]        rr_r, rr_nxt;
  logic [31:0]        len_r, len_nxt;
  logic [30:0]        along_r, along_nxt;
  logic signed [65:0] acc_a_r, acc_a_nxt;
  logic signed [65:0] acc_b_r, acc_b_nxt;
  logic signed [67:0] prod_r;
  logic signed [31:0] ob_r [3];
  logic signed [31:0] ob_nxt [3];
  logic signed [31:0] c_r [3];
  logic signed [31:0] c_nxt [3];
  logic signed [31:0] vec_r [3];
  logic signed [31:0] vec_nxt [3];
  logic signed [UW-1:0] u_r [3];
  logic signed [UW-1:0] u_nxt [3];
  logic signed [UW-1:0] w_r [3];
  logic signed [UW-1:0] w_nxt [3];
  logic signed [31:0] bp_r [3];
  logic signed [31:0] bp_nxt [3];

  logic signed [31:0] ob_in [3];
  logic signed [31:0] chr [3];
  logic signed [31:0] gol [3];

  logic [1:0]         iss_idx;
  logic [1:0]         k_idx;
  logic signed [33:0] ma, mb;
  logic signed [65:0] prod_sh;
  logic signed [65:0] along_full;
  logic [31:0]        vmag;
  logic signed [UW-1:0] qv;

  soa_iter_req_t ireq;
  soa_iter_sts_t ists;
  logic [63:0]   iopa;
  logic [31:0]   iresult;

  assign ob_in[0] = ob_x;
  assign ob_in[1] = ob_y;
  assign ob_in[2] = ob_z;
  assign chr[0]   = cfg.char_x;
  assign chr[1]   = cfg.char_y;
  assign chr[2]   = cfg.char_z;
  assign gol[0]   = cfg.goal_x;
  assign gol[1]   = cfg.goal_y;
  assign gol[2]   = cfg.goal_z;

  soa_iter #(.FRAC_BITS(FRAC_BITS)) u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (ireq),
    .opa    (iopa),
    .opb    (len_r),
    .sts    (ists),
    .result (iresult)
  );

  always_comb begin
    iss_idx = (cnt_r >= 3'd3) ? 2'(cnt_r - 3'd3) : cnt_r[1:0];
    if (iss_idx == 2'd3) begin
      iss_idx = 2'd0;
    end
    k_idx = (cnt_r[1:0] == 2'd3) ? 2'd0 : cnt_r[1:0];
    vmag  = vec_r[k_idx][31] ? (~vec_r[k_idx] + 32'd1) : vec_r[k_idx];
    qv    = $signed({1'b0, iresult[FRAC_BITS:0]});
    if (vec_r[k_idx][31]) begin
      qv = -qv;
    end
    iopa       = (state_r == ST_SQRT) ? acc_a_r[63:0] : {32'd0, vmag};
    prod_sh    = 66'(prod_r >>> FRAC_BITS);
    along_full = acc_a_r >>> FRAC_BITS;

    ma = '0;
    mb = '0;
    case (state_r)
      ST_SUMSQ: begin
        ma = 34'(vec_r[iss_idx]);
        mb = 34'(vec_r[iss_idx]);
      end
      ST_DOT: begin
        ma = 34'(c_r[iss_idx]);
        mb = (cnt_r < 3'd3) ? 34'(u_r[iss_idx]) : 34'(c_r[iss_idx]);
      end
      ST_HIT: begin
        ma = (cnt_r == 3'd0) ? 34'($signed({1'b0, along_r})) : $signed({2'b00, rr_r});
        mb = ma;
      end
      ST_OFF: begin
        ma = 34'(u_r[iss_idx]);
        mb = 34'($signed({1'b0, along_r}));
      end
      ST_PT: begin
        ma = 34'(w_r[iss_idx]);
        mb = $signed({2'b00, rr_r});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pass_nxt      = pass_r;
    best_dist_nxt = best_dist_r;
    last_nxt      = last_r;
    rr_nxt        = rr_r;
    len_nxt       = len_r;
    along_nxt     = along_r;
    acc_a_nxt     = acc_a_r;
    acc_b_nxt     = acc_b_r;
    ob_nxt        = ob_r;
    c_nxt         = c_r;
    vec_nxt       = vec_r;
    u_nxt         = u_r;
    w_nxt         = w_r;
    bp_nxt        = bp_r;
    ireq.start    = 1'b0;
    ireq.mode     = MODE_SQRT;
    res_load      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (item_go) begin
          last_nxt  = ob_last;
          rr_nxt    = {1'b0, ob_radius} + {1'b0, cfg.avoid_margin};
          pass_nxt  = 1'b0;
          cnt_nxt   = '0;
          acc_a_nxt = '0;
          for (int i = 0; i < 3; i++) begin
            ob_nxt[i]  = ob_in[i];
            c_nxt[i]   = sat32(sx32(ob_in[i]) - sx32(chr[i]));
            vec_nxt[i] = sat32(sx32(gol[i]) - sx32(chr[i]));
          end
          if (!cfg.goal_valid || (vec_nxt[0] == 0 && vec_nxt[1] == 0 && vec_nxt[2] == 0))
          begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SUMSQ;
          end
        end
      end
      ST_SUMSQ: begin
        if (cnt_r != 3'd0) begin
          acc_a_nxt = acc_a_r + 66'(prod_r);
        end
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd3) begin
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        ireq.start = 1'b1;
        ireq.mode  = MODE_SQRT;
        state_nxt  = ST_SQWAIT;
      end
      ST_SQWAIT: begin
        if (ists.done) begin
          len_nxt   = iresult;
          cnt_nxt   = '0;
          state_nxt = ST_DIVGO;
        end
      end
      ST_DIVGO, ST_DIVWAIT: begin
        if (state_r == ST_DIVGO && len_r != 32'd0) begin
          ireq.start = 1'b1;
          ireq.mode  = MODE_DIV;
          state_nxt  = ST_DIVWAIT;
        end else if (state_r == ST_DIVGO || ists.done) begin
          if (pass_r) begin
            w_nxt[k_idx] = (len_r == 32'd0) ? '0 : qv;
          end else begin
            u_nxt[k_idx] = (len_r == 32'd0) ? '0 : qv;
          end
          cnt_nxt   = cnt_r + 3'd1;
          state_nxt = ST_DIVGO;
          if (k_idx == 2'd2) begin
            cnt_nxt   = '0;
            acc_a_nxt = '0;
            acc_b_nxt = '0;
            state_nxt = pass_r ? ST_PT : ST_DOT;
          end
        end
      end
      ST_DOT: begin
        if (cnt_r >= 3'd1 && cnt_r <= 3'd3) begin
          acc_a_nxt = acc_a_r + 66'(prod_r);
        end else if (cnt_r >= 3'd4) begin
          acc_b_nxt = acc_b_r + 66'(prod_r);
        end
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd6) begin
          state_nxt = ST_RANGE;
        end
      end
      ST_RANGE: begin
        if (along_full <= 66'sd0 || along_full >= $signed({35'd0, best_dist_r})) begin
          state_nxt = ST_DONE;
        end else begin
          along_nxt = along_full[30:0];
          acc_a_nxt = '0;
          cnt_nxt   = '0;
          state_nxt = ST_HIT;
        end
      end
      ST_HIT: begin
        if (cnt_r != 3'd0) begin
          acc_a_nxt = acc_a_r + 66'(prod_r);
        end
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd2) begin
          state_nxt = ST_HITCHK;
        end
      end
      ST_HITCHK: begin
        cnt_nxt   = '0;
        state_nxt = (acc_b_r < acc_a_r) ? ST_OFF : ST_DONE;
      end
      ST_OFF: begin
        if (cnt_r != 3'd0) begin
          vec_nxt[prv_r] = sat32(prod_sh - sx32(c_r[prv_r]));
        end
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd3) begin
          pass_nxt  = 1'b1;
          acc_a_nxt = '0;
          cnt_nxt   = '0;
          state_nxt = ST_SUMSQ;
        end
      end
      ST_PT: begin
        if (cnt_r != 3'd0) begin
          bp_nxt[prv_r] = sat32(sx32(ob_r[prv_r]) + prod_sh);
        end
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd3) begin
          best_dist_nxt = along_r;
          state_nxt     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (res_ready) begin
          res_load      = 1'b1;
          best_dist_nxt = DIST_NONE;
          for (int i = 0; i < 3; i++) begin
            bp_nxt[i] = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pass_r      <= 1'b0;
      best_dist_r <= DIST_NONE;
      for (int i = 0; i < 3; i++) begin
        bp_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pass_r      <= pass_nxt;
      best_dist_r <= best_dist_nxt;
      bp_r        <= bp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= ma * mb;
    prv_r   <= iss_idx;
    last_r  <= last_nxt;
    rr_r    <= rr_nxt;
    len_r   <= len_nxt;
    along_r <= along_nxt;
    acc_a_r <= acc_a_nxt;
    acc_b_r <= acc_b_nxt;
    ob_r    <= ob_nxt;
    c_r     <= c_nxt;
    vec_r   <= vec_nxt;
    u_r     <= u_nxt;
    w_r     <= w_nxt;
  end

  assign idle         = (state_r == ST_IDLE);
  assign res.found    = (best_dist_r != DIST_NONE);
  assign res.distance = best_dist_r;
  assign res.avoid_x  = bp_r[0];
  assign res.avoid_y  = bp_r[1];
  assign res.avoid_z  = bp_r[2];

  `SOA_ASSERT_IMPLY(a_iter_start_free, ireq.start, !ists.busy)
  `SOA_ASSERT_IMPLY(a_idle_unit_quiet, state_r == ST_IDLE, !ists.busy)
  `SOA_ASSERT_IMPLY(a_best_only_shrinks, !$stable(best_dist_r),
                    (best_dist_r < $past(best_dist_r)) || (best_dist_r == DIST_NONE))
  `SOA_ASSERT_NEXT(a_best_cleared, res_load, best_dist_r == DIST_NONE)

endmodule

FILE: sv/sphere_obstacle_avoidance_top.sv
// ----------------------------------------------------------------------------
// Sphere obstacle avoidance top level
// Configuration registers, request handshake and result register.
// ----------------------------------------------------------------------------
// One obstacle request is taken at a time; in_stall stays high until it has
// been processed. A request with no goal set, or a goal on the character,
// skips the computation. Otherwise the path direction is normalized first;
// an obstacle that misses ends after the range and hit checks, and a hit
// normalizes a second vector. The shared iterative unit resolves one square
// root bit or one quotient bit per cycle. A result is presented on the
// request marked last and waits in an output register while the next
// request is taken.
`include "sphere_obstacle_avoidance_top_assert.svh"
module sphere_obstacle_avoidance_top import soa_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_obstacle_x,
  input  logic signed [31:0] in_obstacle_y,
  input  logic signed [31:0] in_obstacle_z,
  input  logic [30:0]        in_obstacle_radius,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_found,
  output logic [30:0]        out_distance,
  output logic signed [31:0] out_avoid_x,
  output logic signed [31:0] out_avoid_y,
  output logic signed [31:0] out_avoid_z
);

  soa_cfg_t cfg_r;
  soa_res_t res;
  soa_res_t out_r;
  logic     out_valid_r;
  logic     core_idle;
  logic     res_ready;
  logic     res_load;
  logic     cfg_wr;

  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_CHAR_X:     cfg_r.char_x       <= cfg_pwdata;
        REG_CHAR_Y:     cfg_r.char_y       <= cfg_pwdata;
        REG_CHAR_Z:     cfg_r.char_z       <= cfg_pwdata;
        REG_GOAL_X:     cfg_r.goal_x       <= cfg_pwdata;
        REG_GOAL_Y:     cfg_r.goal_y       <= cfg_pwdata;
        REG_GOAL_Z:     cfg_r.goal_z       <= cfg_pwdata;
        REG_GOAL_VALID: cfg_r.goal_valid   <= cfg_pwdata[0];
        REG_MARGIN:     cfg_r.avoid_margin <= cfg_pwdata[30:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_CHAR_X:     cfg_prdata = cfg_r.char_x;
      REG_CHAR_Y:     cfg_prdata = cfg_r.char_y;
      REG_CHAR_Z:     cfg_prdata = cfg_r.char_z;
      REG_GOAL_X:     cfg_prdata = cfg_r.goal_x;
      REG_GOAL_Y:     cfg_prdata = cfg_r.goal_y;
      REG_GOAL_Z:     cfg_prdata = cfg_r.goal_z;
      REG_GOAL_VALID: cfg_prdata = {31'd0, cfg_r.goal_valid};
      REG_MARGIN:     cfg_prdata = {1'b0, cfg_r.avoid_margin};
      default:        cfg_prdata = '0;
    endcase
  end

  assign in_stall  = ~core_idle;
  assign res_ready = ~out_valid_r | ~out_stall;

  soa_core #(.FRAC_BITS(FRAC_BITS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .item_go   (in_valid & core_idle),
    .ob_x      (in_obstacle_x),
    .ob_y      (in_obstacle_y),
    .ob_z      (in_obstacle_z),
    .ob_radius (in_obstacle_radius),
    .ob_last   (in_last),
    .idle      (core_idle),
    .res_ready (res_ready),
    .res_load  (res_load),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_r.found;
  assign out_distance = out_r.distance;
  assign out_avoid_x  = out_r.avoid_x;
  assign out_avoid_y  = out_r.avoid_y;
  assign out_avoid_z  = out_r.avoid_z;

  `SOA_ASSERT_IMPLY(a_found_matches_dist, out_valid_r, out_found == (out_distance != DIST_NONE))
  `SOA_ASSERT_IMPLY(a_load_needs_room, res_load, !out_valid_r || !out_stall)

endmodule
